### rtl/core/smx_pkg.sv
package smx_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int DATA_WIDTH  = 32;
	localparam int ADDR_WIDTH  = $clog2(STACK_DEPTH);
	localparam int SP_WIDTH    = ADDR_WIDTH + 1;
	localparam int NUM_GP      = 6;
	localparam int IP_WIDTH    = 16;
	localparam int REG_IDX_W   = 3;
	localparam int DIV_CNT_W   = $clog2(DATA_WIDTH + 1);

	localparam int S_TDATA_WIDTH = 56;
	localparam int S_TUSER_WIDTH = 4;
	localparam int M_TDATA_WIDTH = 56;

	// register indexes beyond the general registers
	localparam logic [REG_IDX_W-1:0] REG_IP = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SP = 3'd7;

	localparam logic signed [SP_WIDTH:0] SPX_ONE = 1;
	localparam logic signed [SP_WIDTH:0] SPX_TWO = 2;

	typedef enum logic [3:0] {
		OP_PSH = 4'd0,
		OP_POP = 4'd1,
		OP_SET = 4'd2,
		OP_HLT = 4'd3,
		OP_MOV = 4'd4,
		OP_ADD = 4'd5,
		OP_SUB = 4'd6,
		OP_DIV = 4'd7,
		OP_MUL = 4'd8,
		OP_STR = 4'd9,
		OP_LDR = 4'd10,
		OP_IF  = 4'd11,
		OP_LOG = 4'd12
	} opcode_t;

	typedef enum logic [1:0] {
		FLT_NONE    = 2'd0,
		FLT_DIV0    = 2'd1,
		FLT_UNKNOWN = 2'd2,
		FLT_RANGE   = 2'd3
	} fault_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_READ_A,
		ST_READ_B,
		ST_EXEC,
		ST_DIV,
		ST_COMMIT
	} state_t;

	typedef enum logic [2:0] {
		RET_NONE,
		RET_SIMPLE,
		RET_LOAD,
		RET_DIV0,
		RET_ARITH
	} retire_t;

	typedef struct packed {
		logic    clear;
		logic    load;
		logic    rd_top;
		logic    rd_next;
		logic    cap_b;
		logic    calc;
		logic    div_go;
		logic    div_take;
		retire_t retire;
	} cmd_t;

	typedef struct packed {
		logic need_read;
		logic is_load;
		logic is_div;
		logic div_zero;
		logic div_done;
		logic clear_done;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic [1:0]            fault;
		logic [DATA_WIDTH-1:0] log_value;
		logic [REG_IDX_W-1:0]  log_register;
		logic                  log_valid;
		logic                  halted;
		logic [IP_WIDTH-1:0]   next_ip;
	} result_t;

endpackage

### rtl/core/stack_machine_execute_core.sv
// Stack machine execute core: takes one pre-decoded instruction per input word
// and returns one status word with the next fetch address, halt, log and fault
// information. After reset the core zeroes the stack memory (one entry per
// cycle) and accepts no word until that pass ends. From then on it works on
// one instruction at a time: register, immediate, jump and log operations
// retire straight from decode; LDR waits on one stack read and ADD, SUB and
// MUL on two, set by the single read port of the stack memory that fetches the
// two operands one after the other; DIV also waits on the one-bit-per-cycle
// divider (a zero divisor skips it). The result word sits in an output register,
// so a held result only blocks the next one from leaving.
// Once HLT has executed, every later word reports the same IP with halted set.
module stack_machine_execute_core (
	input  logic        clk,
	input  logic        arst_n,
	// instruction words
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [2:0] reg_first, [5:3] reg_second, [37:6] immediate, [53:38] jump_target
	input  logic [smx_pkg::S_TDATA_WIDTH-1:0] s_axis_tdata,
	// [3:0] action
	input  logic [smx_pkg::S_TUSER_WIDTH-1:0] s_axis_tuser,
	// status words
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] next_ip, [16] halted, [17] log_valid, [20:18] log_register,
	// [52:21] log_value, [54:53] fault
	output logic [smx_pkg::M_TDATA_WIDTH-1:0] m_axis_tdata
);

	smx_pkg::cmd_t    cmd;
	smx_pkg::sts_t    sts;
	smx_pkg::result_t out_word;

	// sequencer: clear pass, decode, stack reads, divide wait, retire
	smx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// registers, stack memory, arithmetic and the output register
	smx_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_action      (s_axis_tuser[3:0]),
		.in_reg_first   (s_axis_tdata[2:0]),
		.in_reg_second  (s_axis_tdata[5:3]),
		.in_immediate   (s_axis_tdata[37:6]),
		.in_jump_target (s_axis_tdata[53:38]),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (m_axis_tready),
		.out_valid      (m_axis_tvalid),
		.out_word       (out_word)
	);

	// zero-pad the packed result up to whole bytes
	assign m_axis_tdata = smx_pkg::M_TDATA_WIDTH'(out_word);

`ifndef SYNTHESIS
	// one instruction in flight: the input closes right after a word is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while an instruction is in flight");

	// a fresh result only follows a cycle in which the input was closed
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared without a retire cycle");

	// the divider never finishes in the cycle after it starts
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_go |=> !sts.div_done)
		else $error("divider reported done right after start");
`endif

endmodule

### rtl/core/smx_ram.sv
module smx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/smx_div.sv
module smx_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [smx_pkg::DATA_WIDTH-1:0]  dividend,
	input  logic [smx_pkg::DATA_WIDTH-1:0]  divisor,
	output logic                            done,
	output logic [smx_pkg::DATA_WIDTH-1:0]  quotient
);

	logic                           busy_q;
	logic                           done_q;
	logic                           neg_q;
	logic [smx_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [smx_pkg::DATA_WIDTH-1:0] ua_q;
	logic [smx_pkg::DATA_WIDTH-1:0] rem_q;
	logic [smx_pkg::DATA_WIDTH-1:0] quo_q;
	logic [smx_pkg::DATA_WIDTH-1:0] ub;
	logic [smx_pkg::DATA_WIDTH-1:0] ua;
	logic [smx_pkg::DATA_WIDTH:0]   rem_sh;
	logic [smx_pkg::DATA_WIDTH:0]   diff;

	// magnitudes; the most negative value maps onto itself as unsigned
	assign ub = dividend[smx_pkg::DATA_WIDTH-1] ? -dividend : dividend;
	assign ua = divisor[smx_pkg::DATA_WIDTH-1] ? -divisor : divisor;

	assign rem_sh = {rem_q, quo_q[smx_pkg::DATA_WIDTH-1]};
	assign diff   = rem_sh - {1'b0, ua_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == smx_pkg::DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= smx_pkg::DIV_CNT_W'(smx_pkg::DATA_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - smx_pkg::DIV_CNT_W'(1);
				if (cnt_q == smx_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// one quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= ua;
			rem_q <= '0;
			quo_q <= ub;
			neg_q <= dividend[smx_pkg::DATA_WIDTH-1] ^ divisor[smx_pkg::DATA_WIDTH-1];
		end else if (busy_q) begin
			if (!diff[smx_pkg::DATA_WIDTH]) begin
				rem_q <= diff[smx_pkg::DATA_WIDTH-1:0];
				quo_q <= {quo_q[smx_pkg::DATA_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[smx_pkg::DATA_WIDTH-1:0];
				quo_q <= {quo_q[smx_pkg::DATA_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -quo_q : quo_q;

endmodule

### rtl/core/smx_ctrl.sv
module smx_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  smx_pkg::sts_t sts,
	output smx_pkg::cmd_t cmd
);

	smx_pkg::state_t state_q;
	smx_pkg::state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smx_pkg::ST_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			smx_pkg::ST_CLEAR: begin
				if (sts.clear_done) state_n = smx_pkg::ST_IDLE;
			end
			smx_pkg::ST_IDLE: begin
				if (in_valid) state_n = smx_pkg::ST_DECODE;
			end
			smx_pkg::ST_DECODE: begin
				if (sts.need_read) state_n = smx_pkg::ST_READ_A;
				else if (sts.out_free) state_n = smx_pkg::ST_IDLE;
			end
			smx_pkg::ST_READ_A: begin
				if (!sts.is_load) state_n = smx_pkg::ST_READ_B;
				else if (sts.out_free) state_n = smx_pkg::ST_IDLE;
			end
			smx_pkg::ST_READ_B: begin
				state_n = smx_pkg::ST_EXEC;
			end
			smx_pkg::ST_EXEC: begin
				if (!sts.is_div) state_n = smx_pkg::ST_COMMIT;
				else if (!sts.div_zero) state_n = smx_pkg::ST_DIV;
				else if (sts.out_free) state_n = smx_pkg::ST_IDLE;
			end
			smx_pkg::ST_DIV: begin
				if (sts.div_done) state_n = smx_pkg::ST_COMMIT;
			end
			smx_pkg::ST_COMMIT: begin
				if (sts.out_free) state_n = smx_pkg::ST_IDLE;
			end
			default: state_n = smx_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			smx_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
			end
			smx_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			smx_pkg::ST_DECODE: begin
				if (sts.need_read) cmd.rd_top = 1'b1;
				else if (sts.out_free) cmd.retire = smx_pkg::RET_SIMPLE;
			end
			smx_pkg::ST_READ_A: begin
				if (!sts.is_load) cmd.rd_next = 1'b1;
				else if (sts.out_free) cmd.retire = smx_pkg::RET_LOAD;
			end
			smx_pkg::ST_READ_B: begin
				cmd.cap_b = 1'b1;
			end
			smx_pkg::ST_EXEC: begin
				if (!sts.is_div) cmd.calc = 1'b1;
				else if (!sts.div_zero) cmd.div_go = 1'b1;
				else if (sts.out_free) cmd.retire = smx_pkg::RET_DIV0;
			end
			smx_pkg::ST_DIV: begin
				cmd.div_take = sts.div_done;
			end
			smx_pkg::ST_COMMIT: begin
				if (sts.out_free) cmd.retire = smx_pkg::RET_ARITH;
			end
			default: cmd = '0;
		endcase
	end

endmodule

### rtl/core/smx_dpath.sv
module smx_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [3:0]                      in_action,
	input  logic [smx_pkg::REG_IDX_W-1:0]   in_reg_first,
	input  logic [smx_pkg::REG_IDX_W-1:0]   in_reg_second,
	input  logic [31:0]                     in_immediate,
	input  logic [smx_pkg::IP_WIDTH-1:0]    in_jump_target,
	input  smx_pkg::cmd_t                   cmd,
	output smx_pkg::sts_t                   sts,
	input  logic                            out_ready,
	output logic                            out_valid,
	output smx_pkg::result_t                out_word
);

	localparam int DW = smx_pkg::DATA_WIDTH;
	localparam int AW = smx_pkg::ADDR_WIDTH;
	localparam int SW = smx_pkg::SP_WIDTH;
	localparam int IW = smx_pkg::IP_WIDTH;
	localparam int RW = smx_pkg::REG_IDX_W;

	function automatic logic [DW-1:0] read_reg(
		input logic [RW-1:0]                   idx,
		input logic [IW-1:0]                   ipread,
		input logic [smx_pkg::NUM_GP-1:0][DW-1:0] gp,
		input logic [SW-1:0]                   sp
	);
		logic [DW-1:0] v;
		if (idx == smx_pkg::REG_IP) v = DW'(ipread);
		else if (idx == smx_pkg::REG_SP) v = {{(DW-SW){sp[SW-1]}}, sp};
		else v = gp[idx];
		return v;
	endfunction

	function automatic logic in_stack(input logic signed [SW:0] x);
		return (x >= 0) && (x < smx_pkg::STACK_DEPTH);
	endfunction

	// instruction latch
	logic [3:0]    act_q;
	logic [RW-1:0] r1_q;
	logic [RW-1:0] r2_q;
	logic [DW-1:0] imm_q;
	logic [IW-1:0] tgt_q;

	// architectural state
	logic [smx_pkg::NUM_GP-1:0][DW-1:0] gp_q;
	logic [IW-1:0] ip_q;
	logic [SW-1:0] sp_q;
	logic          halt_q;

	logic [DW-1:0] opa_q;
	logic [DW-1:0] opb_q;
	logic [DW-1:0] res_q;
	logic [AW-1:0] clr_q;
	logic          out_valid_q;
	smx_pkg::result_t out_q;

	logic [DW-1:0] ram_rdata;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;

	logic          div_done;
	logic [DW-1:0] div_quo;

	logic signed [SW:0] spx;
	logic signed [SW:0] sp_up;
	logic signed [SW:0] sp_dn;
	logic [DW-1:0] rd_r1;
	logic [DW-1:0] rd_r2;
	logic          is_arith;
	logic          ret_act;

	// retire outcome
	logic [2:0]    len;
	logic          jump;
	logic          ipwr;
	logic [IW-1:0] ipw;
	logic          rw_en;
	logic [DW-1:0] rw_val;
	logic          gp_we;
	logic          a_wr;
	logic          sp_set;
	logic [SW-1:0] sp_new;
	logic          push;
	logic [DW-1:0] push_val;
	logic          halt_set;
	logic          logv;
	logic [DW-1:0] logval;
	smx_pkg::fault_t flt;
	logic [IW-1:0] nip;

	assign spx      = $signed({sp_q[SW-1], sp_q});
	assign sp_up    = spx + smx_pkg::SPX_ONE;
	assign sp_dn    = spx - smx_pkg::SPX_ONE;
	assign rd_r1    = read_reg(r1_q, ip_q + IW'(1), gp_q, sp_q);
	assign rd_r2    = read_reg(r2_q, ip_q + IW'(2), gp_q, sp_q);
	assign is_arith = act_q inside {smx_pkg::OP_ADD, smx_pkg::OP_SUB,
		smx_pkg::OP_DIV, smx_pkg::OP_MUL};
	assign ret_act  = cmd.retire != smx_pkg::RET_NONE;

	always_comb begin
		len      = 3'd1;
		jump     = 1'b0;
		ipwr     = 1'b0;
		ipw      = '0;
		rw_en    = 1'b0;
		rw_val   = '0;
		gp_we    = 1'b0;
		a_wr     = 1'b0;
		sp_set   = 1'b0;
		sp_new   = sp_q;
		push     = 1'b0;
		push_val = imm_q;
		halt_set = 1'b0;
		logv     = 1'b0;
		logval   = '0;
		flt      = smx_pkg::FLT_NONE;
		if (!halt_q) begin
			case (cmd.retire)
				smx_pkg::RET_SIMPLE: begin
					case (act_q)
						smx_pkg::OP_PSH, smx_pkg::OP_STR: begin
							len      = 3'd2;
							push_val = (act_q == smx_pkg::OP_PSH) ? imm_q : rd_r1;
							if (in_stack(sp_up)) begin
								push   = 1'b1;
								sp_set = 1'b1;
								sp_new = sp_up[SW-1:0];
							end else begin
								flt = smx_pkg::FLT_RANGE;
							end
						end
						smx_pkg::OP_POP: begin
							if (in_stack(spx)) begin
								sp_set = 1'b1;
								sp_new = sp_dn[SW-1:0];
							end else begin
								flt = smx_pkg::FLT_RANGE;
							end
						end
						smx_pkg::OP_SET: begin
							len    = 3'd3;
							rw_en  = 1'b1;
							rw_val = imm_q;
						end
						smx_pkg::OP_HLT: begin
							halt_set = 1'b1;
						end
						smx_pkg::OP_MOV: begin
							len    = 3'd3;
							rw_en  = 1'b1;
							rw_val = rd_r2;
						end
						smx_pkg::OP_ADD, smx_pkg::OP_SUB,
						smx_pkg::OP_DIV, smx_pkg::OP_MUL: begin
							// only reached with the stack out of range
							flt = smx_pkg::FLT_RANGE;
						end
						smx_pkg::OP_LDR: begin
							len = 3'd2;
							flt = smx_pkg::FLT_RANGE;
						end
						smx_pkg::OP_IF: begin
							len  = 3'd4;
							jump = (rd_r1 == imm_q);
						end
						smx_pkg::OP_LOG: begin
							len    = 3'd2;
							logv   = 1'b1;
							logval = rd_r1;
						end
						default: begin
							flt = smx_pkg::FLT_UNKNOWN;
						end
					endcase
				end
				smx_pkg::RET_LOAD: begin
					len    = 3'd2;
					rw_en  = 1'b1;
					rw_val = ram_rdata;
				end
				smx_pkg::RET_DIV0: begin
					sp_set = 1'b1;
					sp_new = SW'(spx - smx_pkg::SPX_TWO);
					flt    = smx_pkg::FLT_DIV0;
				end
				smx_pkg::RET_ARITH: begin
					sp_set = 1'b1;
					sp_new = sp_dn[SW-1:0];
					a_wr   = 1'b1;
				end
				default: begin
					len = 3'd1;
				end
			endcase
			// register write, which may land on IP or SP
			if (rw_en) begin
				if (r1_q == smx_pkg::REG_IP) begin
					ipwr = 1'b1;
					ipw  = rw_val[IW-1:0];
				end else if (r1_q == smx_pkg::REG_SP) begin
					sp_set = 1'b1;
					sp_new = rw_val[SW-1:0];
				end else begin
					gp_we = 1'b1;
				end
			end
		end
		if (halt_q) nip = ip_q;
		else if (jump) nip = tgt_q;
		else if (ipwr) nip = ipw + IW'(1);
		else nip = ip_q + IW'(len);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sp_up[AW-1:0];
		ram_wdata = push_val;
		if (cmd.clear) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (a_wr) begin
			ram_we    = 1'b1;
			ram_waddr = sp_dn[AW-1:0];
			ram_wdata = res_q;
		end else if (push) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re    = cmd.rd_top | cmd.rd_next;
	assign ram_raddr = cmd.rd_top ? sp_q[AW-1:0] : sp_dn[AW-1:0];

	smx_ram #(
		.WIDTH (DW),
		.DEPTH (smx_pkg::STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	smx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (opb_q),
		.divisor  (opa_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gp_q        <= '0;
			ip_q        <= '0;
			sp_q        <= '1;
			halt_q      <= 1'b0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + AW'(1);
			if (ret_act) begin
				ip_q        <= nip;
				out_valid_q <= 1'b1;
				if (halt_set) halt_q <= 1'b1;
				if (sp_set) sp_q <= sp_new;
				if (gp_we) gp_q[r1_q] <= rw_val;
				if (a_wr) gp_q[0] <= res_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_action;
			r1_q  <= in_reg_first;
			r2_q  <= in_reg_second;
			imm_q <= DW'($signed(in_immediate));
			tgt_q <= in_jump_target;
		end
		if (cmd.rd_next) opa_q <= ram_rdata;
		if (cmd.cap_b) opb_q <= ram_rdata;
		if (cmd.calc) begin
			case (act_q)
				smx_pkg::OP_ADD: res_q <= opa_q + opb_q;
				smx_pkg::OP_SUB: res_q <= opb_q - opa_q;
				default:         res_q <= DW'(opa_q * opb_q);
			endcase
		end else if (cmd.div_take) begin
			res_q <= div_quo;
		end
		if (ret_act) begin
			out_q.next_ip      <= nip;
			out_q.halted       <= halt_q | halt_set;
			out_q.log_valid    <= logv;
			out_q.log_register <= logv ? r1_q : '0;
			out_q.log_value    <= 32'($signed(logval));
			out_q.fault        <= flt;
		end
	end

	assign sts.need_read  = !halt_q && (((act_q == smx_pkg::OP_LDR) && in_stack(spx))
		|| (is_arith && in_stack(spx) && in_stack(sp_dn)));
	assign sts.is_load    = act_q == smx_pkg::OP_LDR;
	assign sts.is_div     = act_q == smx_pkg::OP_DIV;
	assign sts.div_zero   = opa_q == '0;
	assign sts.div_done   = div_done;
	assign sts.clear_done = clr_q == '1;
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

### tb/sv/tb_top.sv
module tb_top;
	import smx_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_WAIT = 40;
	localparam int RANDOM_WORDS = 1700;
	localparam int SP_UNKNOWN = 1000;

	typedef struct packed {
		logic [3:0]  action;
		logic [2:0]  reg_first;
		logic [2:0]  reg_second;
		logic [31:0] immediate;
		logic [15:0] jump_target;
		logic        wait_drain;
	} instr_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [S_TDATA_WIDTH-1:0] s_axis_tdata = '0;
	logic [S_TUSER_WIDTH-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [M_TDATA_WIDTH-1:0] m_axis_tdata;

	stack_machine_execute_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// machine state mirrored by the predictor
	logic [31:0] regs_q [0:NUM_GP-1];
	logic [15:0] ip_q;
	logic [SP_WIDTH-1:0] sp_q;
	logic [31:0] stack_q [0:STACK_DEPTH-1];
	logic halt_q;

	instr_t program_words[$];
	result_t pending_status[$];
	instr_t cur_instr;
	result_t next_status;
	int words_sent = 0;
	int words_back = 0;
	int mismatches = 0;
	int depth_guess = -1;
	bit pause_next = 1'b0;
	int hold_left = 0;
	int stall_left = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit tx_fire;
	int idle_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit fits(input int s);
		return s >= 0 && s < STACK_DEPTH;
	endfunction

	// IP reads as the address of the operand word; SP reads sign-extended
	function automatic logic [31:0] reg_value(input logic [2:0] r, input logic [15:0] ip_read);
		if (r == REG_IP)
			return {16'h0, ip_read};
		if (r == REG_SP)
			return {{(32 - SP_WIDTH){sp_q[SP_WIDTH-1]}}, sp_q};
		return regs_q[r];
	endfunction

	function automatic void store_reg(input logic [2:0] r, input logic [31:0] v,
			inout logic ip_written, inout logic [15:0] ip_new);
		if (r == REG_IP) begin
			ip_written = 1'b1;
			ip_new = v[15:0];
		end else if (r == REG_SP) begin
			sp_q = v[SP_WIDTH-1:0];
		end else begin
			regs_q[r] = v;
		end
	endfunction

	// Execute one instruction on the mirrored state and return its status word.
	function automatic result_t execute_instr(input instr_t it);
		result_t res;
		int sp_now;
		int len;
		logic ip_written;
		logic jump;
		logic [15:0] ip_new;
		logic [31:0] a, b, val, ua, ub;
		res = '0;
		sp_now = $signed(sp_q);
		len = 1;
		ip_written = 1'b0;
		jump = 1'b0;
		ip_new = '0;
		if (halt_q) begin
			res.next_ip = ip_q;
			res.halted = 1'b1;
			return res;
		end
		case (it.action)
			OP_PSH: begin
				len = 2;
				if (fits(sp_now + 1)) begin
					stack_q[sp_now + 1] = it.immediate;
					sp_q = SP_WIDTH'(sp_now + 1);
				end else begin
					res.fault = FLT_RANGE;
				end
			end
			OP_POP: begin
				if (fits(sp_now))
					sp_q = SP_WIDTH'(sp_now - 1);
				else
					res.fault = FLT_RANGE;
			end
			OP_SET: begin
				len = 3;
				store_reg(it.reg_first, it.immediate, ip_written, ip_new);
			end
			OP_HLT: begin
				halt_q = 1'b1;
			end
			OP_MOV: begin
				len = 3;
				store_reg(it.reg_first, reg_value(it.reg_second, ip_q + 16'd2),
					ip_written, ip_new);
			end
			OP_ADD, OP_SUB, OP_DIV, OP_MUL: begin
				if (!fits(sp_now) || !fits(sp_now - 1)) begin
					res.fault = FLT_RANGE;
				end else begin
					a = stack_q[sp_now];
					b = stack_q[sp_now - 1];
					if (it.action == OP_DIV && a == '0) begin
						// zero divisor: both operands gone, nothing pushed
						sp_q = SP_WIDTH'(sp_now - 2);
						res.fault = FLT_DIV0;
					end else begin
						case (it.action)
							OP_ADD: val = a + b;
							OP_SUB: val = b - a;
							OP_MUL: val = a * b;
							default: begin
								// truncate toward zero on magnitudes; MIN / -1 wraps to MIN
								ub = b[31] ? -b : b;
								ua = a[31] ? -a : a;
								val = ub / ua;
								if (a[31] ^ b[31])
									val = -val;
							end
						endcase
						stack_q[sp_now - 1] = val;
						sp_q = SP_WIDTH'(sp_now - 1);
						regs_q[0] = val;
					end
				end
			end
			OP_STR: begin
				len = 2;
				if (fits(sp_now + 1)) begin
					stack_q[sp_now + 1] = reg_value(it.reg_first, ip_q + 16'd1);
					sp_q = SP_WIDTH'(sp_now + 1);
				end else begin
					res.fault = FLT_RANGE;
				end
			end
			OP_LDR: begin
				len = 2;
				if (fits(sp_now))
					store_reg(it.reg_first, stack_q[sp_now], ip_written, ip_new);
				else
					res.fault = FLT_RANGE;
			end
			OP_IF: begin
				len = 4;
				jump = reg_value(it.reg_first, ip_q + 16'd1) == it.immediate;
			end
			OP_LOG: begin
				len = 2;
				res.log_valid = 1'b1;
				res.log_register = it.reg_first;
				res.log_value = reg_value(it.reg_first, ip_q + 16'd1);
			end
			default: begin
				res.fault = FLT_UNKNOWN;
			end
		endcase
		if (jump)
			ip_q = it.jump_target;
		else if (ip_written)
			ip_q = ip_new + 16'd1;
		else
			ip_q = ip_q + 16'(len);
		res.next_ip = ip_q;
		res.halted = halt_q;
		return res;
	endfunction

	// Queue one instruction; keep a rough idea of the stack depth so the
	// generator can steer away from long runs of range faults.
	task automatic issue(input logic [3:0] op, input logic [2:0] rf, input logic [2:0] rs,
			input logic [31:0] imm, input logic [15:0] tgt);
		instr_t it;
		it.action = op;
		it.reg_first = rf;
		it.reg_second = rs;
		it.immediate = imm;
		it.jump_target = tgt;
		it.wait_drain = pause_next;
		pause_next = 1'b0;
		program_words.push_back(it);
		case (op)
			OP_PSH, OP_STR:
				if (depth_guess < STACK_DEPTH - 1) depth_guess++;
			OP_POP:
				if (depth_guess >= 0) depth_guess--;
			OP_ADD, OP_SUB, OP_DIV, OP_MUL:
				if (depth_guess >= 1) depth_guess--;
			OP_SET:
				if (rf == REG_SP) depth_guess = $signed(imm[SP_WIDTH-1:0]);
			OP_MOV, OP_LDR:
				if (rf == REG_SP) depth_guess = SP_UNKNOWN;
			default: ;
		endcase
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			3: return 32'hffff_ffff;
			4: return 32'($urandom_range(0, 20)) - 32'd10;
			default: return $urandom;
		endcase
	endfunction

	task automatic note_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("status word %0d: %s expected %h, got %h", words_back, field, want, got);
	endtask

	// Stimulus: a directed opening, a random body of well-formed sequences with
	// noise mixed in, and a halt near the end, followed by words it must ignore, since halt sticks until reset.
	initial begin
		logic [31:0] v, w;
		logic [2:0] r, r2;
		logic [3:0] op;

		// reset view, empty-stack faults
		issue(OP_LOG, REG_SP, 3'd0, 32'h0, 16'h0);
		issue(OP_POP, 3'd0, 3'd7, 32'hffff_ffff, 16'hffff);
		issue(OP_ADD, 3'd7, 3'd0, 32'h0, 16'h0);
		// overflowing add, MIN / -1, divide by zero
		issue(OP_PSH, 3'd0, 3'd0, 32'h7fff_ffff, 16'h0);
		issue(OP_PSH, 3'd0, 3'd0, 32'h1, 16'h0);
		issue(OP_ADD, 3'd0, 3'd0, 32'h0, 16'h0);
		issue(OP_PSH, 3'd0, 3'd0, 32'hffff_ffff, 16'h0);
		issue(OP_DIV, 3'd0, 3'd0, 32'h0, 16'h0);
		issue(OP_PSH, 3'd0, 3'd0, 32'h0, 16'h0);
		issue(OP_DIV, 3'd0, 3'd0, 32'h0, 16'h0);
		// signed divide rounding, sub order, mul
		issue(OP_PSH, 3'd0, 3'd0, 32'hffff_fff9, 16'h0);
		issue(OP_PSH, 3'd0, 3'd0, 32'h2, 16'h0);
		issue(OP_DIV, 3'd0, 3'd0, 32'h0, 16'h0);
		issue(OP_PSH, 3'd0, 3'd0, 32'h5, 16'h0);
		issue(OP_SUB, 3'd0, 3'd0, 32'h0, 16'h0);
		issue(OP_PSH, 3'd0, 3'd0, 32'hffff_fffd, 16'h0);
		issue(OP_MUL, 3'd0, 3'd0, 32'h0, 16'h0);
		// register moves, reads of IP and SP, pushes of SP itself
		issue(OP_SET, 3'd1, 3'd0, 32'hdead_beef, 16'h0);
		issue(OP_MOV, 3'd2, REG_IP, 32'h0, 16'h0);
		issue(OP_STR, REG_SP, 3'd0, 32'h0, 16'h0);
		issue(OP_STR, REG_IP, 3'd0, 32'h0, 16'h0);
		issue(OP_LDR, REG_IP, 3'd0, 32'h0, 16'h0);
		// full stack
		issue(OP_SET, REG_SP, 3'd0, 32'd255, 16'h0);
		issue(OP_PSH, 3'd0, 3'd0, 32'h1234_5678, 16'h0);
		// IP wrap, taken and untaken compare, unknown opcodes
		issue(OP_SET, REG_IP, 3'd0, 32'h0000_ffff, 16'h0);
		issue(OP_IF, REG_IP, 3'd0, 32'h1, 16'hffff);
		issue(OP_IF, 3'd0, 3'd0, 32'h0, 16'h1234);
		issue(4'd13, 3'd5, 3'd5, 32'h0, 16'h0);
		issue(4'd15, 3'd5, 3'd5, 32'h0, 16'h0);

		pause_next = 1'b1;
		while (program_words.size() < RANDOM_WORDS + 30) begin
			if (depth_guess < -1 || depth_guess > 200 || $urandom_range(0, 39) == 0) begin
				case ($urandom_range(0, 9))
					0: v = $urandom;
					1: v = 32'($urandom_range(250, 255));
					default: v = 32'($urandom_range(0, 40)) - 32'd1;
				endcase
				issue(OP_SET, REG_SP, 3'($urandom), v, 16'($urandom));
			end
			if ($urandom_range(0, 299) == 0)
				pause_next = 1'b1;
			r = 3'($urandom);
			r2 = 3'($urandom);
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					op = 4'(OP_ADD + $urandom_range(0, 3));
					issue(OP_PSH, r, r2, pick_word(), 16'($urandom));
					case ($urandom_range(0, 7))
						0: v = 32'h0;
						1: v = 32'hffff_ffff;
						default: v = pick_word();
					endcase
					issue(OP_PSH, r2, r, v, 16'($urandom));
					issue(op, r, r2, $urandom, 16'($urandom));
				end
				3: begin
					issue(($urandom_range(0, 2) != 0) ? OP_PSH : OP_POP, r, r2, pick_word(),
						16'($urandom));
				end
				4: begin
					issue(OP_STR, r, r2, $urandom, 16'($urandom));
					issue(OP_LDR, r2, r, $urandom, 16'($urandom));
				end
				5: begin
					issue(OP_SET, r, r2, pick_word(), 16'($urandom));
					issue(OP_MOV, r2, r, $urandom, 16'($urandom));
					issue(OP_LOG, r2, r, $urandom, 16'($urandom));
				end
				6: begin
					// compare right after a write, so the jump is mostly taken
					v = pick_word();
					issue(OP_SET, r, r2, v, 16'($urandom));
					if (r == REG_IP)
						w = {16'h0, v[15:0] + 16'd2};
					else if (r == REG_SP)
						w = {{(32 - SP_WIDTH){v[SP_WIDTH-1]}}, v[SP_WIDTH-1:0]};
					else
						w = v;
					if ($urandom_range(0, 3) == 0)
						w = w ^ (32'h1 << $urandom_range(0, 31));
					issue(OP_IF, r, r2, w, 16'($urandom));
				end
				7: begin
					issue(OP_LOG, r, r2, $urandom, 16'($urandom));
					issue(OP_IF, r2, r, pick_word(), 16'($urandom));
				end
				8: begin
					// any opcode but halt, unknown ones included
					op = 4'($urandom_range(0, 14));
					if (op >= OP_HLT)
						op = op + 4'd1;
					issue(op, r, r2, pick_word(), 16'($urandom));
				end
				default: begin
					issue(OP_MOV, r, r2, $urandom, 16'($urandom));
					issue(OP_LDR, r2, r, $urandom, 16'($urandom));
				end
			endcase
		end

		// halt, then words that must all be ignored
		issue(OP_HLT, 3'd0, 3'd0, 32'h0, 16'h0);
		issue(OP_PSH, 3'd0, 3'd0, 32'h5555_5555, 16'h0);
		issue(OP_LOG, 3'd0, 3'd0, 32'h0, 16'h0);
		issue(4'd14, 3'd0, 3'd0, 32'h0, 16'h0);

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (program_words.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (words_back < words_sent) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_status.size() != 0)
			mismatches += pending_status.size();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Driver: predict each accepted word, then present the next one after a
	// drawn gap. A word marked for draining holds back until every status is in.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			foreach (regs_q[i]) regs_q[i] = '0;
			foreach (stack_q[i]) stack_q[i] = '0;
			ip_q = '0;
			sp_q = '1;
			halt_q = 1'b0;
			hold_left = 0;
		end else begin
			tx_fire = s_axis_tvalid && s_axis_tready;
			if (tx_fire) begin
				next_status = execute_instr(cur_instr);
				pending_status.push_back(next_status);
				words_sent <= words_sent + 1;
				if ($urandom_range(0, 63) == 0)
					tx_calm = !tx_calm;
				hold_left = tx_calm ? 0 : $urandom_range(0, 9);
			end
			if (tx_fire || !s_axis_tvalid) begin
				if (hold_left > 0) begin
					hold_left--;
					s_axis_tvalid <= 1'b0;
				end else if (program_words.size() != 0 && !(program_words[0].wait_drain &&
						(tx_fire || words_sent != words_back))) begin
					cur_instr = program_words.pop_front();
					s_axis_tdata <= {2'b00, cur_instr.jump_target, cur_instr.immediate,
						cur_instr.reg_second, cur_instr.reg_first};
					s_axis_tuser <= cur_instr.action;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check every status word against the oldest prediction, then
	// stall the result side for a drawn number of cycles.
	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
				if (pending_status.size() == 0) begin
					note_mismatch("unexpected word, next_ip", 32'h0, {16'h0, got.next_ip});
				end else begin
					want = pending_status.pop_front();
					if (got.next_ip !== want.next_ip)
						note_mismatch("next_ip", {16'h0, want.next_ip}, {16'h0, got.next_ip});
					if (got.halted !== want.halted)
						note_mismatch("halted", {31'h0, want.halted}, {31'h0, got.halted});
					if (got.log_valid !== want.log_valid)
						note_mismatch("log_valid", {31'h0, want.log_valid},
							{31'h0, got.log_valid});
					if (got.log_register !== want.log_register)
						note_mismatch("log_register", {29'h0, want.log_register},
							{29'h0, got.log_register});
					if (got.log_value !== want.log_value)
						note_mismatch("log_value", want.log_value, got.log_value);
					if (got.fault !== want.fault)
						note_mismatch("fault", {30'h0, want.fault}, {30'h0, got.fault});
				end
				words_back <= words_back + 1;
				if ($urandom_range(0, 63) == 0)
					rx_calm = !rx_calm;
				stall_left = rx_calm ? 0 : $urandom_range(0, 9);
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if neither side moves a word for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule

### stack_machine_execute_core.f
rtl/core/smx_pkg.sv
rtl/core/smx_ram.sv
rtl/core/smx_div.sv
rtl/core/smx_ctrl.sv
rtl/core/smx_dpath.sv
rtl/core/stack_machine_execute_core.sv
tb/sv/tb_top.sv
